// ----- hw/rtl/frvm_pkg.sv -----
// Package with opcode codes, sequencer states and helper types for the frame VM executor.
`timescale 1ns / 1ps
package frvm_pkg;

    typedef enum logic [4:0] {
        OP_ADD      = 5'd0,
        OP_ADDEBP   = 5'd1,
        OP_SUB      = 5'd2,
        OP_MUL      = 5'd3,
        OP_DIV      = 5'd4,
        OP_CONST    = 5'd5,
        OP_COPY     = 5'd6,
        OP_COPYRET  = 5'd7,
        OP_PRINT    = 5'd8,
        OP_JMP      = 5'd9,
        OP_JMPFALSE = 5'd10,
        OP_GT       = 5'd11,
        OP_LT       = 5'd12,
        OP_EQ       = 5'd13,
        OP_LOADIND  = 5'd14,
        OP_STOREIND = 5'd15,
        OP_AND      = 5'd16,
        OP_OR       = 5'd17,
        OP_CALL     = 5'd18,
        OP_RET      = 5'd19,
        OP_PUSHBASE = 5'd20,
        OP_PUSHVAR  = 5'd21,
        OP_POPBASE  = 5'd22,
        OP_BASESP   = 5'd23,
        OP_SPBASE   = 5'd24,
        OP_ADDSP    = 5'd25,
        OP_SETRET   = 5'd26
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RDX,
        ST_RDY,
        ST_RDA,
        ST_RDP,
        ST_WAITP,
        ST_EXEC,
        ST_DIVW,
        ST_WRITE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

// ----- hw/rtl/frvm_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module frvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- hw/rtl/frvm_div.sv -----
// Iterative signed divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module frvm_div
    import frvm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        neg_reg, neg_next;
    logic [31:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [32:0] trial;

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg[31:0], quo_reg[31]} - {1'b0, dvs_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            neg_next  = req.dividend[31] ^ req.divisor[31];
            quo_next  = req.dividend[31] ? -req.dividend : req.dividend;
            dvs_next  = req.divisor[31] ? -req.divisor : req.divisor;
            rem_next  = 33'd0;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[31:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (neg_reg)
                begin
                    quo_next = -quo_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule

// ----- hw/rtl/frame_relative_vm_executor.sv -----
// Top level of the frame-relative VM executor: sequencer, registers and RAM port control.
//
// One instruction per input item on the s_axis channel; tdata carries kind, arg_a,
// arg_b and arg_c. One result item per instruction leaves on m_axis: next_pc,
// print_valid, print_value and div_zero.
// Each item passes through the states RDX, RDY, RDA, RDP, WAITP, EXEC, WRITE and OUT in
// order around the single RAM port: four reads (both sources, the destination word and
// one dependent read) and, if the opcode stores a result, one write use it one per cycle.
// A division with a nonzero divisor also waits in DIVW for the iterative divider.
// s_axis_tready is high only while the sequencer is idle, so a new item is accepted
// only after the previous one has left the OUT state.
// RAM_DEPTH must be a power of two; RAM addresses wrap by keeping the low bits.
// After reset the RAM is cleared one word a cycle, all RAM_DEPTH words, before the
// first item is accepted; pc, stack pointer, frame base and return register
// reset to zero. A stalled receiver holds the result in the output register while
// the next item is executed; that item then waits until the held result is taken.
`timescale 1ns / 1ps
module frame_relative_vm_executor
    import frvm_pkg::*;
#(
    parameter int RAM_DEPTH = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // kind[4:0], arg_a[36:5], arg_b[68:37], arg_c[100:69], zero fill to 104
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // next_pc[15:0], print_valid[16], print_value[48:17], div_zero[49], zero fill
    output logic [55:0]  m_axis_tdata
);
    localparam int AW = $clog2(RAM_DEPTH);

    state_t state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [15:0] pc_reg, pc_next;
    logic [31:0] sp_reg, sp_next, bp_reg, bp_next, rv_reg, rv_next;
    logic [4:0]  kind_reg;
    logic [31:0] a_reg, b_reg, c_reg;
    logic [31:0] x_reg, x_next, y_reg, y_next, p_reg, p_next;
    logic [31:0] w_reg, w_next;
    logic [AW-1:0] wa_reg, wa_next;
    logic        we_reg, we_next;
    logic        dz_reg, dz_next;
    logic [55:0] out_reg, out_next;
    logic        ov_reg, ov_next;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_wdata, ram_rdata;
    div_req_t      dreq;
    div_rsp_t      drsp;
    logic [63:0]   prod;

    function automatic logic [AW-1:0] wrap(input logic [31:0] v);
        return v[AW-1:0];
    endfunction

    frvm_ram #(.WIDTH(32), .DEPTH(RAM_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    frvm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    logic [31:0] fa_a, fa_b, fa_c;
    assign fa_a = bp_reg + a_reg;
    assign fa_b = bp_reg + b_reg;
    assign fa_c = bp_reg + c_reg;
    assign prod = x_reg * y_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == AW'(RAM_DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (s_axis_tvalid && s_axis_tready) state_next = ST_RDX;
            ST_RDX:   state_next = ST_RDY;
            ST_RDY:   state_next = ST_RDA;
            ST_RDA:   state_next = ST_RDP;
            ST_RDP:   state_next = ST_WAITP;
            ST_WAITP: state_next = ST_EXEC;
            ST_EXEC:  state_next = (kind_reg == OP_DIV && y_reg != 32'd0) ? ST_DIVW : ST_WRITE;
            ST_DIVW:  if (drsp.done) state_next = ST_WRITE;
            ST_WRITE: state_next = ST_OUT;
            ST_OUT:   if (!ov_reg) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // RAM port: reads issued in RDX(b), RDY(c), RDA(a); each read's data is captured in the state after it.
    // RDP captures the RDA data in p and issues the dependent read: indirect through x or pop at sp-1.
    always_comb
    begin
        clr_next = clr_reg;
        ram_we = 1'b0;
        ram_addr = '0;
        ram_wdata = w_reg;
        x_next = x_reg;
        y_next = y_reg;
        p_next = p_reg;
        w_next = w_reg;
        wa_next = wa_reg;
        we_next = we_reg;
        dz_next = dz_reg;
        pc_next = pc_reg;
        sp_next = sp_reg;
        bp_next = bp_reg;
        rv_next = rv_reg;
        out_next = out_reg;
        ov_next = ov_reg;
        dreq.start = 1'b0;
        dreq.dividend = x_reg;
        dreq.divisor = y_reg;
        if (ov_reg && m_axis_tready)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                ram_addr = clr_reg;
                ram_wdata = 32'd0;
                clr_next = clr_reg + AW'(1);
            end
            ST_RDX:
            begin
                ram_addr = wrap(fa_b);
                we_next = 1'b0;
                dz_next = 1'b0;
            end
            ST_RDY:
            begin
                ram_addr = wrap(fa_c);
                x_next = ram_rdata;
            end
            ST_RDA:
            begin
                ram_addr = wrap(fa_a);
                y_next = ram_rdata;
            end
            ST_RDP:
            begin
                p_next = ram_rdata;
                if (kind_reg == OP_LOADIND)
                    ram_addr = wrap(x_reg);
                else
                    ram_addr = wrap(sp_reg - 32'd1);
            end
            ST_WAITP:
            begin
                // w holds the late read (indirect load or pop)
                w_next = ram_rdata;
            end
            ST_EXEC:
            begin
                pc_next = pc_reg + 16'd1;
                wa_next = wrap(fa_a);
                case (kind_reg)
                    OP_ADD:    begin we_next = 1'b1; w_next = x_reg + y_reg; end
                    OP_ADDEBP: begin we_next = 1'b1; w_next = x_reg + bp_reg; end
                    OP_SUB:    begin we_next = 1'b1; w_next = x_reg - y_reg; end
                    OP_MUL:    begin we_next = 1'b1; w_next = prod[31:0]; end
                    OP_DIV:
                    begin
                        we_next = 1'b1;
                        w_next = 32'd0;
                        if (y_reg == 32'd0)
                            dz_next = 1'b1;
                        else
                            dreq.start = 1'b1;
                    end
                    OP_CONST:  begin we_next = 1'b1; w_next = b_reg; end
                    OP_COPY:   begin we_next = 1'b1; w_next = x_reg; end
                    OP_COPYRET: begin we_next = 1'b1; w_next = rv_reg; end
                    OP_PRINT:  ;
                    OP_JMP:    pc_next = a_reg[15:0];
                    OP_JMPFALSE: if (p_reg == 32'd0) pc_next = b_reg[15:0];
                    OP_GT: begin we_next = 1'b1;
                        w_next = {31'd0, $signed(x_reg) > $signed(y_reg)}; end
                    OP_LT: begin we_next = 1'b1;
                        w_next = {31'd0, $signed(x_reg) < $signed(y_reg)}; end
                    OP_EQ: begin we_next = 1'b1; w_next = {31'd0, x_reg == y_reg}; end
                    OP_LOADIND: we_next = 1'b1;
                    OP_STOREIND:
                    begin
                        we_next = 1'b1;
                        wa_next = wrap(p_reg);
                        w_next = x_reg;
                    end
                    OP_AND: begin we_next = 1'b1;
                        w_next = {31'd0, (x_reg != 32'd0) && (y_reg != 32'd0)}; end
                    OP_OR: begin we_next = 1'b1;
                        w_next = {31'd0, (x_reg != 32'd0) || (y_reg != 32'd0)}; end
                    OP_CALL:
                    begin
                        we_next = 1'b1;
                        wa_next = wrap(sp_reg);
                        w_next = {16'd0, pc_reg};
                        sp_next = sp_reg + 32'd1;
                        pc_next = a_reg[15:0];
                    end
                    OP_RET:
                    begin
                        pc_next = w_reg[15:0] + 16'd1;
                        sp_next = sp_reg - 32'd1 - a_reg;
                    end
                    OP_PUSHBASE:
                    begin
                        we_next = 1'b1;
                        wa_next = wrap(sp_reg);
                        w_next = bp_reg;
                        sp_next = sp_reg + 32'd1;
                    end
                    OP_PUSHVAR:
                    begin
                        we_next = 1'b1;
                        wa_next = wrap(sp_reg);
                        w_next = p_reg;
                        sp_next = sp_reg + 32'd1;
                    end
                    OP_POPBASE:
                    begin
                        bp_next = w_reg;
                        sp_next = sp_reg - 32'd1;
                    end
                    OP_BASESP: bp_next = sp_reg;
                    OP_SPBASE: sp_next = bp_reg;
                    OP_ADDSP:  sp_next = sp_reg + a_reg;
                    OP_SETRET: rv_next = p_reg;
                    default: ;
                endcase
            end
            ST_DIVW:
            begin
                if (drsp.done)
                    w_next = drsp.quotient;
            end
            ST_WRITE:
            begin
                ram_we = we_reg;
                ram_addr = wa_reg;
            end
            ST_OUT:
            begin
                if (!ov_reg)
                begin
                    ov_next = 1'b1;
                    out_next = {6'd0, dz_reg,
                        (kind_reg == OP_PRINT) ? p_reg : 32'd0,
                        kind_reg == OP_PRINT, pc_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            pc_reg    <= 16'd0;
            sp_reg    <= 32'd0;
            bp_reg    <= 32'd0;
            rv_reg    <= 32'd0;
            ov_reg    <= 1'b0;
            we_reg    <= 1'b0;
            dz_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pc_reg    <= pc_next;
            sp_reg    <= sp_next;
            bp_reg    <= bp_next;
            rv_reg    <= rv_next;
            ov_reg    <= ov_next;
            we_reg    <= we_next;
            dz_reg    <= dz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            kind_reg <= s_axis_tdata[4:0];
            a_reg    <= s_axis_tdata[36:5];
            b_reg    <= s_axis_tdata[68:37];
            c_reg    <= s_axis_tdata[100:69];
        end
        x_reg   <= x_next;
        y_reg   <= y_next;
        p_reg   <= p_next;
        w_reg   <= w_next;
        wa_reg  <= wa_next;
        out_reg <= out_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = out_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("input accepted while busy");
    a_div_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> (state_reg == ST_DIVW))
        else $error("divider finished outside its wait state");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
endmodule
